>>> src/morse_key_timing_decoder_macros.svh
// Assertion macros for the Morse key timing decoder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef MORSE_KEY_TIMING_DECODER_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MKTD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

`define MKTD_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`define MKTD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define MKTD_ASSERT_ALWAYS(label, cond)
`define MKTD_ASSERT_IMPLY(label, ante, cons)
`define MKTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/mktd_pkg.sv
`default_nettype none

package mktd_pkg;

  localparam int TICK_W = 16;
  localparam int MAX_SYMBOLS = 5;
  localparam int OVERLONG = MAX_SYMBOLS + 1;
  localparam int COUNT_W = $clog2(OVERLONG + 1);
  localparam int NUM_CODES = 36;
  localparam int INDEX_W = 6;
  localparam int MARK_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] DOT_MIN_RESET = 16'd469;
  localparam logic [TICK_W-1:0] DASH_MIN_RESET = 16'd3125;
  localparam logic [TICK_W-1:0] DASH_MAX_RESET = 16'd6250;
  localparam logic [TICK_W-1:0] GAP_CLEAR_RESET = 16'd6250;

  localparam logic [CFG_IDX_W-1:0] REG_DOT_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CLEAR = 2'd3;

  localparam logic ACTION_EDGE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef enum logic [MARK_W-1:0] {
    MARK_NONE  = 2'd0,
    MARK_DOT   = 2'd1,
    MARK_DASH  = 2'd2,
    MARK_CLEAR = 2'd3
  } mark_t;

  typedef struct packed {
    logic dot;
    logic dash;
    logic long_gap;
  } edge_class_t;

  typedef struct packed {
    logic [COUNT_W-1:0]     len;
    logic [MAX_SYMBOLS-1:0] bits;
  } code_t;

  function automatic code_t mk_code(input int len, input int bits);
    code_t c;
    c.len = COUNT_W'(len);
    c.bits = MAX_SYMBOLS'(bits);
    return c;
  endfunction

  // Bit k of a code is symbol k, with a dash as 1.
  function automatic code_t code_entry(input logic [INDEX_W-1:0] k);
    code_t c;
    unique case (k)
      6'd0: c = mk_code(2, 2);
      6'd1: c = mk_code(4, 1);
      6'd2: c = mk_code(4, 5);
      6'd3: c = mk_code(3, 1);
      6'd4: c = mk_code(1, 0);
      6'd5: c = mk_code(4, 4);
      6'd6: c = mk_code(3, 3);
      6'd7: c = mk_code(4, 0);
      6'd8: c = mk_code(2, 0);
      6'd9: c = mk_code(4, 14);
      6'd10: c = mk_code(3, 5);
      6'd11: c = mk_code(4, 2);
      6'd12: c = mk_code(2, 3);
      6'd13: c = mk_code(2, 1);
      6'd14: c = mk_code(3, 7);
      6'd15: c = mk_code(4, 6);
      6'd16: c = mk_code(4, 11);
      6'd17: c = mk_code(3, 2);
      6'd18: c = mk_code(3, 0);
      6'd19: c = mk_code(1, 1);
      6'd20: c = mk_code(3, 4);
      6'd21: c = mk_code(4, 8);
      6'd22: c = mk_code(3, 6);
      6'd23: c = mk_code(4, 9);
      6'd24: c = mk_code(4, 13);
      6'd25: c = mk_code(4, 3);
      6'd26: c = mk_code(5, 30);
      6'd27: c = mk_code(5, 28);
      6'd28: c = mk_code(5, 24);
      6'd29: c = mk_code(5, 16);
      6'd30: c = mk_code(5, 0);
      6'd31: c = mk_code(5, 1);
      6'd32: c = mk_code(5, 3);
      6'd33: c = mk_code(5, 7);
      6'd34: c = mk_code(5, 15);
      6'd35: c = mk_code(5, 31);
      default: c = mk_code(0, 0);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/mktd_classify.sv
`default_nettype none

module mktd_classify (
  input  wire logic [mktd_pkg::TICK_W-1:0] timestamp,
  input  wire logic [mktd_pkg::TICK_W-1:0] last_edge_time,
  input  wire logic [mktd_pkg::TICK_W-1:0] dot_min_ticks,
  input  wire logic [mktd_pkg::TICK_W-1:0] dash_min_ticks,
  input  wire logic [mktd_pkg::TICK_W-1:0] dash_max_ticks,
  input  wire logic [mktd_pkg::TICK_W-1:0] gap_clear_ticks,
  output mktd_pkg::edge_class_t            edge_class
);
  import mktd_pkg::*;

  logic [TICK_W-1:0] interval;

  // The timer wraps, so the difference is taken modulo its width.
  assign interval = timestamp - last_edge_time;

  always_comb begin
    edge_class.dot = (interval >= dot_min_ticks) && (interval < dash_min_ticks);
    edge_class.dash = (interval >= dash_min_ticks) && (interval < dash_max_ticks);
    edge_class.long_gap = interval > gap_clear_ticks;
  end

endmodule

`default_nettype wire

>>> src/mktd_lookup.sv
`default_nettype none

module mktd_lookup (
  input  wire logic [mktd_pkg::MAX_SYMBOLS-1:0] symbol_bits,
  input  wire logic [mktd_pkg::COUNT_W-1:0]     symbol_count,
  output logic                                  hit,
  output logic [mktd_pkg::INDEX_W-1:0]          index
);
  import mktd_pkg::*;

  logic  in_range;
  code_t entry;

  assign in_range = (symbol_count >= COUNT_W'(1)) && (symbol_count <= COUNT_W'(MAX_SYMBOLS));

  // Scanned from the top down so that the lowest matching entry wins.
  always_comb begin
    hit = 1'b0;
    index = '0;
    entry = '0;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      entry = code_entry(INDEX_W'(k));
      if (in_range && (entry.len == symbol_count) && (entry.bits == symbol_bits)) begin
        hit = 1'b1;
        index = INDEX_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/morse_key_timing_decoder.sv
// Morse key timing decoder.
// Input channel (in_valid, in_stall): one beat per key edge (action 0, with
// the timer capture in timestamp) or per timeout tick (action 1). Output
// channel (out_valid, out_stall): exactly one result beat per input beat, in
// order, carrying mark, char_valid and char_index.
// Configuration: cfg_write with cfg_index and cfg_data writes one of the four
// threshold registers at the clock edge; write only while the block is idle.
// A beat that is accepted enters the input register, and its result is
// loaded into the output register when it advances. Throughput is one beat
// per cycle while the receiver does not stall; the whole decision is one
// subtraction, five compares and a 36-entry code match.
// When the receiver stalls, the result holds in the output register and the
// next beat waits in the input register; in_stall rises only when both are
// full and the output is stalled.
// Reset (rst, synchronous) empties both registers, loads the threshold reset
// values, clears the symbol buffer and the last edge time, and arms the next
// edge as a press start.
`default_nettype none
`include "morse_key_timing_decoder_macros.svh"

module morse_key_timing_decoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [mktd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mktd_pkg::TICK_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             action,
  input  wire logic [mktd_pkg::TICK_W-1:0]      timestamp,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mktd_pkg::MARK_W-1:0]           mark,
  output logic                                  char_valid,
  output logic [mktd_pkg::INDEX_W-1:0]          char_index
);
  import mktd_pkg::*;

  logic [TICK_W-1:0] dot_min_ticks;
  logic [TICK_W-1:0] dash_min_ticks;
  logic [TICK_W-1:0] dash_max_ticks;
  logic [TICK_W-1:0] gap_clear_ticks;

  logic              in_full;
  logic              in_action;
  logic [TICK_W-1:0] in_timestamp;

  logic [TICK_W-1:0]      last_edge_time;
  logic                   press_phase;
  logic [MAX_SYMBOLS-1:0] symbol_bits;
  logic [COUNT_W-1:0]     symbol_count;

  logic [TICK_W-1:0]      last_edge_time_next;
  logic                   press_phase_next;
  logic [MAX_SYMBOLS-1:0] symbol_bits_next;
  logic [COUNT_W-1:0]     symbol_count_next;
  mark_t                  mark_next;
  logic                   char_valid_next;
  logic [INDEX_W-1:0]     char_index_next;

  logic                   advance;
  logic                   in_accept;
  edge_class_t            edge_class;
  logic                   hit;
  logic [INDEX_W-1:0]     hit_index;
  logic [MAX_SYMBOLS-1:0] append_bits;
  logic [COUNT_W-1:0]     append_count;

  assign advance = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  mktd_classify u_classify (
    .timestamp       (in_timestamp),
    .last_edge_time  (last_edge_time),
    .dot_min_ticks   (dot_min_ticks),
    .dash_min_ticks  (dash_min_ticks),
    .dash_max_ticks  (dash_max_ticks),
    .gap_clear_ticks (gap_clear_ticks),
    .edge_class      (edge_class)
  );

  mktd_lookup u_lookup (
    .symbol_bits  (symbol_bits),
    .symbol_count (symbol_count),
    .hit          (hit),
    .index        (hit_index)
  );

  // A full buffer goes overlong instead of taking another symbol.
  always_comb begin
    append_bits = symbol_bits;
    append_count = COUNT_W'(OVERLONG);
    if (symbol_count < COUNT_W'(MAX_SYMBOLS)) begin
      append_count = symbol_count + COUNT_W'(1);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        if (symbol_count == COUNT_W'(i)) begin
          append_bits[i] = edge_class.dash;
        end
      end
    end
  end

  always_comb begin
    last_edge_time_next = last_edge_time;
    press_phase_next = press_phase;
    symbol_bits_next = symbol_bits;
    symbol_count_next = symbol_count;
    mark_next = MARK_NONE;
    char_valid_next = 1'b0;
    char_index_next = '0;
    if (in_action == ACTION_TICK) begin
      char_valid_next = hit;
      char_index_next = hit_index;
      symbol_bits_next = '0;
      symbol_count_next = '0;
    end else begin
      last_edge_time_next = in_timestamp;
      press_phase_next = !press_phase;
      if (press_phase) begin
        if (edge_class.dot || edge_class.dash) begin
          symbol_bits_next = append_bits;
          symbol_count_next = append_count;
          mark_next = edge_class.dash ? MARK_DASH : MARK_DOT;
        end
      end else if (edge_class.long_gap) begin
        symbol_bits_next = '0;
        symbol_count_next = '0;
        mark_next = MARK_CLEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min_ticks <= DOT_MIN_RESET;
      dash_min_ticks <= DASH_MIN_RESET;
      dash_max_ticks <= DASH_MAX_RESET;
      gap_clear_ticks <= GAP_CLEAR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOT_MIN: dot_min_ticks <= cfg_data;
        REG_DASH_MIN: dash_min_ticks <= cfg_data;
        REG_DASH_MAX: dash_max_ticks <= cfg_data;
        REG_GAP_CLEAR: gap_clear_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_action <= action;
      in_timestamp <= timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      press_phase <= 1'b0;
      symbol_bits <= '0;
      symbol_count <= '0;
    end else if (advance) begin
      last_edge_time <= last_edge_time_next;
      press_phase <= press_phase_next;
      symbol_bits <= symbol_bits_next;
      symbol_count <= symbol_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mark <= mark_next;
      char_valid <= char_valid_next;
      char_index <= char_index_next;
    end
  end

  `MKTD_ASSERT_ALWAYS(a_count_range, symbol_count <= COUNT_W'(OVERLONG))
  `MKTD_ASSERT_IMPLY(a_char_no_mark, out_valid && char_valid, mark == MARK_NONE)
  `MKTD_ASSERT_IMPLY(a_char_index_range, out_valid && char_valid, char_index < INDEX_W'(NUM_CODES))
  `MKTD_ASSERT_NEXT(a_tick_clears, advance && (in_action == ACTION_TICK), symbol_count == '0)

endmodule

`default_nettype wire
